>>> sv/smoothed_heaviside_dirac_macros.svh
// assertion macros for the smoothed heaviside / dirac top level
// no dependencies
`ifndef SMOOTHED_HEAVISIDE_DIRAC_MACROS_SVH
`define SMOOTHED_HEAVISIDE_DIRAC_MACROS_SVH

// condition implies consequence in the same cycle
`define SHD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shd assertion failed");

// condition implies consequence in the next cycle
`define SHD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shd assertion failed");

`endif

>>> sv/shd_pkg.sv
// shared types and constants of the smoothed heaviside / dirac pipeline
// no dependencies
`timescale 1ns / 1ps
package shd_pkg;

  localparam int NUM_STAGES   = 15;
  localparam int FRONT_STAGES = 3;
  localparam int SINE_STAGES  = 8;
  localparam int BACK_STAGES  = NUM_STAGES - FRONT_STAGES;

  localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
  localparam logic [30:0] Q30_HALF = 31'h2000_0000;

  typedef logic [30:0] shd_coef_arr_t [0:6];

  // q30 coefficients of sin(pi z / 2), horner form in z^2
  localparam shd_coef_arr_t SIN_COEF = '{
    31'd1686629713, 31'd693598668, 31'd85569306, 31'd5026995,
    31'd172272, 31'd3864, 31'd61
  };

  localparam logic [30:0] INV_PI_Q30   = 31'd341782638;
  localparam logic [30:0] INV_2PI2_Q30 = 31'd54396397;

  typedef enum logic {
    REG_BAND = 1'b0,
    REG_INV  = 1'b1
  } shd_reg_t;

  typedef struct packed {
    logic        neg;
    logic        below;
    logic        above;
    logic        cneg;
    logic [30:0] u;
  } shd_side_t;

endpackage

>>> sv/shd_front.sv
// front stages: band test, coordinate product, saturation and sine argument fold
// depends on shd_pkg
`timescale 1ns / 1ps
module shd_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic [shd_pkg::FRONT_STAGES-1:0]   stage_en,
  input  logic [31:0]                        level_value,
  input  logic [30:0]                        band_half_width,
  input  logic [30:0]                        inverse_band_half_width,
  output logic [30:0]                        zs,
  output logic [30:0]                        zc,
  output shd_pkg::shd_side_t                 side
);

  localparam int TWO_F = 2 * FRAC_BITS;
  localparam int SH_R  = (TWO_F >= 30) ? (TWO_F - 30) : 0;
  localparam int SH_L  = (TWO_F < 30) ? (30 - TWO_F) : 0;

  logic signed [32:0] psi_x;
  logic signed [32:0] eps_x;
  logic [31:0]        mag_nxt;

  logic [31:0] mag0_r;
  logic        neg0_r, below0_r, above0_r;
  logic [62:0] m1_r;
  logic        neg1_r, below1_r, above1_r;

  logic [30:0] u_c;
  logic        cneg_c;
  logic [31:0] u2_c;
  logic [30:0] zs_nxt, zc_nxt;

  logic [30:0]        zs_r, zc_r;
  shd_pkg::shd_side_t side_r;

  assign psi_x   = {level_value[31], level_value};
  assign eps_x   = {2'b00, band_half_width};
  assign mag_nxt = level_value[31] ? (32'd0 - level_value) : level_value;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      mag0_r   <= mag_nxt;
      neg0_r   <= level_value[31];
      below0_r <= (psi_x < -eps_x);
      above0_r <= (psi_x > eps_x);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      m1_r     <= {31'd0, mag0_r} * {32'd0, inverse_band_half_width};
      neg1_r   <= neg0_r;
      below1_r <= below0_r;
      above1_r <= above0_r;
    end
  end

  always_comb begin
    if ((m1_r >> TWO_F) != 63'd0) begin
      u_c = shd_pkg::Q30_ONE;
    end else begin
      u_c = 31'((m1_r >> SH_R) << SH_L);
    end
    cneg_c = (u_c > shd_pkg::Q30_HALF);
    u2_c   = {u_c, 1'b0};
    if (cneg_c) begin
      zs_nxt = 31'({1'b0, shd_pkg::Q30_ONE - u_c, 1'b0});
      zc_nxt = 31'(u2_c - {1'b0, shd_pkg::Q30_ONE});
    end else begin
      zs_nxt = 31'(u2_c);
      zc_nxt = 31'({1'b0, shd_pkg::Q30_ONE} - u2_c);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      zs_r         <= zs_nxt;
      zc_r         <= zc_nxt;
      side_r.neg   <= neg1_r;
      side_r.below <= below1_r;
      side_r.above <= above1_r;
      side_r.cneg  <= cneg_c;
      side_r.u     <= u_c;
    end
  end

  assign zs   = zs_r;
  assign zc   = zc_r;
  assign side = side_r;

endmodule

>>> sv/shd_qsine.sv
// pipelined quarter sine sin(pi z / 2): z squared, one horner step per stage, then final product and clamp
// depends on shd_pkg
`timescale 1ns / 1ps
module shd_qsine (
  input  logic                             clk,
  input  logic [shd_pkg::SINE_STAGES-1:0]  stage_en,
  input  logic [30:0]                      z,
  output logic [30:0]                      y
);

  logic [30:0] zp_r  [0:6];
  logic [30:0] z2p_r [0:5];
  logic [30:0] rp_r  [1:6];
  logic [61:0] sq_prod;
  logic [61:0] fin_prod;
  logic [30:0] y_r;

  assign sq_prod = {31'd0, z} * {31'd0, z};

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      zp_r[0]  <= z;
      z2p_r[0] <= sq_prod[60:30];
    end
  end

  for (genvar j = 1; j <= 6; j++) begin : g_horner
    logic [30:0] r_in;
    logic [61:0] prod;
    if (j == 1) begin : g_first
      assign r_in = shd_pkg::SIN_COEF[6];
    end else begin : g_rest
      assign r_in = rp_r[j-1];
    end
    assign prod = {31'd0, r_in} * {31'd0, z2p_r[j-1]};
    always_ff @(posedge clk) begin
      if (stage_en[j]) begin
        rp_r[j] <= shd_pkg::SIN_COEF[6-j] - prod[60:30];
        zp_r[j] <= zp_r[j-1];
      end
    end
    if (j < 6) begin : g_z2
      always_ff @(posedge clk) begin
        if (stage_en[j]) begin
          z2p_r[j] <= z2p_r[j-1];
        end
      end
    end
  end

  assign fin_prod = {31'd0, rp_r[6]} * {31'd0, zp_r[6]};

  always_ff @(posedge clk) begin
    if (stage_en[7]) begin
      if (fin_prod[61:30] > {1'b0, shd_pkg::Q30_ONE}) begin
        y_r <= shd_pkg::Q30_ONE;
      end else begin
        y_r <= fin_prod[60:30];
      end
    end
  end

  assign y = y_r;

endmodule

>>> sv/shd_back.sv
// back stages: side delay line, delta, heaviside, scaled terms and saturation
// depends on shd_pkg
`timescale 1ns / 1ps
module shd_back (
  input  logic                             clk,
  input  logic [shd_pkg::BACK_STAGES-1:0]  stage_en,
  input  shd_pkg::shd_side_t               side_in,
  input  logic [30:0]                      s_in,
  input  logic [30:0]                      c_in,
  input  logic [30:0]                      inverse_band_half_width,
  output logic [31:0]                      dirac_value,
  output logic [16:0]                      heaviside_value,
  output logic [16:0]                      scaled_heaviside,
  output logic [31:0]                      scaled_dirac
);

  function automatic logic [16:0] clamp_q16(input logic signed [34:0] sum);
    logic [16:0] res;
    if (sum < 35'sd0) begin
      res = 17'd0;
    end else if (sum > 35'sh0_8000_0000) begin
      res = 17'd65536;
    end else begin
      res = sum[31:15];
    end
    return res;
  endfunction

  shd_pkg::shd_side_t side_d_r [0:7];

  for (genvar i = 0; i < 8; i++) begin : g_delay
    always_ff @(posedge clk) begin
      if (stage_en[i]) begin
        if (i == 0) begin
          side_d_r[i] <= side_in;
        end else begin
          side_d_r[i] <= side_d_r[(i == 0) ? 0 : i-1];
        end
      end
    end
  end

  // stage 11
  logic [31:0] qc_c;
  logic [62:0] dprod_c;
  logic [61:0] ts_prod_c, sq_prod_c, x2_prod_c;
  logic [31:0] onepx_c;
  logic        inband11_c;

  logic [31:0] dirac11_r;
  logic [30:0] ts11_r, sq11_r, x2h11_r, s11_r;
  logic [31:0] onepx11_r;
  shd_pkg::shd_side_t side11_r;

  assign inband11_c = !side_d_r[7].below && !side_d_r[7].above;
  assign qc_c = side_d_r[7].cneg ? ({1'b0, shd_pkg::Q30_ONE} - {1'b0, c_in})
                                 : ({1'b0, shd_pkg::Q30_ONE} + {1'b0, c_in});
  assign dprod_c   = {31'd0, qc_c} * {32'd0, inverse_band_half_width};
  assign ts_prod_c = {31'd0, s_in} * {31'd0, shd_pkg::INV_PI_Q30};
  assign sq_prod_c = {31'd0, s_in} * {31'd0, s_in};
  assign x2_prod_c = {31'd0, side_d_r[7].u} * {31'd0, side_d_r[7].u};
  assign onepx_c = side_d_r[7].neg ? ({1'b0, shd_pkg::Q30_ONE} - {1'b0, side_d_r[7].u})
                                   : ({1'b0, shd_pkg::Q30_ONE} + {1'b0, side_d_r[7].u});

  always_ff @(posedge clk) begin
    if (stage_en[8]) begin
      dirac11_r <= inband11_c ? dprod_c[62:31] : 32'd0;
      ts11_r    <= ts_prod_c[60:30];
      sq11_r    <= sq_prod_c[60:30];
      x2h11_r   <= x2_prod_c[61:31];
      s11_r     <= s_in;
      onepx11_r <= onepx_c;
      side11_r  <= side_d_r[7];
    end
  end

  // stage 12
  logic [61:0]        sqt_prod_c;
  logic [62:0]        st_prod_c;
  logic signed [34:0] ut_c, hsum_c;
  logic [16:0]        heav_c;

  logic [31:0] dirac12_r;
  logic [16:0] heav12_r;
  logic [30:0] sqt12_r, x2h12_r;
  logic [31:0] st12_r;
  shd_pkg::shd_side_t side12_r;

  assign sqt_prod_c = {31'd0, sq11_r} * {31'd0, shd_pkg::INV_2PI2_Q30};
  assign st_prod_c  = {32'd0, s11_r} * {31'd0, onepx11_r};
  assign ut_c = 35'($signed({1'b0, side11_r.u})) + 35'($signed({1'b0, ts11_r}));
  assign hsum_c = side11_r.neg ? (35'($signed({1'b0, shd_pkg::Q30_ONE})) - ut_c)
                               : (35'($signed({1'b0, shd_pkg::Q30_ONE})) + ut_c);

  always_comb begin
    priority if (side11_r.below) begin
      heav_c = 17'd0;
    end else if (side11_r.above) begin
      heav_c = 17'd65536;
    end else begin
      heav_c = clamp_q16(hsum_c);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[9]) begin
      dirac12_r <= dirac11_r;
      heav12_r  <= heav_c;
      sqt12_r   <= sqt_prod_c[60:30];
      st12_r    <= st_prod_c[61:30];
      x2h12_r   <= x2h11_r;
      side12_r  <= side11_r;
    end
  end

  // stage 13
  logic [62:0] stp_prod_c;
  logic [48:0] sd_prod_c;

  logic [31:0] dirac13_r, sdirac13_r;
  logic [16:0] heav13_r;
  logic [30:0] sqt13_r, x2h13_r, stp13_r;
  shd_pkg::shd_side_t side13_r;

  assign stp_prod_c = {31'd0, st12_r} * {32'd0, shd_pkg::INV_PI_Q30};
  assign sd_prod_c  = {32'd0, heav12_r} * {17'd0, dirac12_r};

  always_ff @(posedge clk) begin
    if (stage_en[10]) begin
      dirac13_r  <= dirac12_r;
      sdirac13_r <= (sd_prod_c[48:47] != 2'b00) ? 32'hFFFF_FFFF : sd_prod_c[46:15];
      heav13_r   <= heav12_r;
      sqt13_r    <= sqt12_r;
      x2h13_r    <= x2h12_r;
      stp13_r    <= stp_prod_c[60:30];
      side13_r   <= side12_r;
    end
  end

  // stage 14
  logic signed [34:0] base_c, tsum_c, ssum_c;
  logic [16:0]        hscale_c;

  logic [31:0] dirac14_r, sdirac14_r;
  logic [16:0] heav14_r, hscale14_r;

  assign base_c = 35'($signed({1'b0, shd_pkg::Q30_HALF})) + 35'($signed({1'b0, x2h13_r}))
                + 35'($signed({1'b0, sqt13_r}));
  assign tsum_c = 35'($signed({1'b0, side13_r.u})) + 35'($signed({1'b0, stp13_r}));
  assign ssum_c = side13_r.neg ? (base_c - tsum_c) : (base_c + tsum_c);

  always_comb begin
    priority if (side13_r.below) begin
      hscale_c = 17'd0;
    end else if (side13_r.above) begin
      hscale_c = 17'd65536;
    end else begin
      hscale_c = clamp_q16(ssum_c);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[11]) begin
      dirac14_r   <= dirac13_r;
      sdirac14_r  <= sdirac13_r;
      heav14_r    <= heav13_r;
      hscale14_r  <= hscale_c;
    end
  end

  assign dirac_value      = dirac14_r;
  assign heaviside_value  = heav14_r;
  assign scaled_heaviside = hscale14_r;
  assign scaled_dirac     = sdirac14_r;

endmodule

>>> sv/smoothed_heaviside_dirac.sv
// top level: config registers, stage valid/enable control and datapath instances
// depends on shd_pkg, shd_front, shd_qsine, shd_back, smoothed_heaviside_dirac_macros.svh
//
//   channel   | direction | handshake           | payload
//   in_       | in        | in_valid, in_stall  | in_level_value
//   out_      | out       | out_valid, out_stall| dirac, heaviside, scaled heaviside/dirac
//   cfg (apb) | in        | psel, penable       | paddr, pwdata, prdata
//
// one item per cycle sustained while out_ is not stalled
// the 8-stage horner sine pipeline runs beside the back side delay line, after the front stages
// a stalled output only holds stages that are full; bubbles close up behind it
// rst_n synchronous; config registers reset to 1.0 in Q.FRAC_BITS, no clearing pass
`timescale 1ns / 1ps
`include "smoothed_heaviside_dirac_macros.svh"
module smoothed_heaviside_dirac #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_level_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_dirac_value,
  output logic [16:0] out_heaviside_value,
  output logic [16:0] out_scaled_heaviside,
  output logic [31:0] out_scaled_dirac,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int N = shd_pkg::NUM_STAGES;
  localparam logic [30:0] REG_RESET = 31'(1) << FRAC_BITS;

  logic [30:0] band_half_width_r;
  logic [30:0] inverse_band_half_width_r;
  logic        wr_en;
  shd_pkg::shd_reg_t reg_sel;

  logic [N-1:0] v_r;
  logic [N-1:0] en;

  logic [30:0]        zs, zc, s_val, c_val;
  shd_pkg::shd_side_t side;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = shd_pkg::shd_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_half_width_r         <= REG_RESET;
      inverse_band_half_width_r <= REG_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        shd_pkg::REG_BAND: band_half_width_r         <= pwdata[30:0];
        shd_pkg::REG_INV:  inverse_band_half_width_r <= pwdata[30:0];
        default:           band_half_width_r         <= band_half_width_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      shd_pkg::REG_BAND: prdata = {1'b0, band_half_width_r};
      shd_pkg::REG_INV:  prdata = {1'b0, inverse_band_half_width_r};
      default:           prdata = 32'd0;
    endcase
  end

  // a stage holds only when it and every stage after it are full and out_ is stalled
  for (genvar i = 0; i < N; i++) begin : g_en
    assign en[i] = !out_stall || !(&v_r[N-1:i]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < N; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[N-1];

  shd_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk                     (clk),
    .stage_en                (en[shd_pkg::FRONT_STAGES-1:0]),
    .level_value             (in_level_value),
    .band_half_width         (band_half_width_r),
    .inverse_band_half_width (inverse_band_half_width_r),
    .zs                      (zs),
    .zc                      (zc),
    .side                    (side)
  );

  shd_qsine u_sin (
    .clk      (clk),
    .stage_en (en[shd_pkg::FRONT_STAGES +: shd_pkg::SINE_STAGES]),
    .z        (zs),
    .y        (s_val)
  );

  shd_qsine u_cos (
    .clk      (clk),
    .stage_en (en[shd_pkg::FRONT_STAGES +: shd_pkg::SINE_STAGES]),
    .z        (zc),
    .y        (c_val)
  );

  shd_back u_back (
    .clk                     (clk),
    .stage_en                (en[N-1:shd_pkg::FRONT_STAGES]),
    .side_in                 (side),
    .s_in                    (s_val),
    .c_in                    (c_val),
    .inverse_band_half_width (inverse_band_half_width_r),
    .dirac_value             (out_dirac_value),
    .heaviside_value         (out_heaviside_value),
    .scaled_heaviside        (out_scaled_heaviside),
    .scaled_dirac            (out_scaled_dirac)
  );

  `SHD_ASSERT_IMPLIES(a_empty_out_takes_in, clk, rst_n, !out_valid, !in_stall)
  `SHD_ASSERT_IMPLIES(a_heav_range, clk, rst_n, out_valid, (out_heaviside_value <= 17'd65536) && (out_scaled_heaviside <= 17'd65536))
  `SHD_ASSERT_IMPLIES(a_zero_heav_zero_sd, clk, rst_n, out_valid && (out_heaviside_value == 17'd0), out_scaled_dirac == 32'd0)
  `SHD_ASSERT_NEXT(a_full_stall_holds_in, clk, rst_n, (&v_r) && out_stall, in_stall || !out_stall)

endmodule

>>> tb/smoothed_heaviside_dirac_tb.sv
// testbench for smoothed_heaviside_dirac: random and directed level samples with a bit-exact
// predictor, whole-result compares with per-field reports, and config writes over the apb-style port
// depends on shd_pkg and the smoothed_heaviside_dirac rtl
`timescale 1ns / 1ps
module smoothed_heaviside_dirac_tb;

  typedef struct packed {
    logic [31:0] dirac;
    logic [16:0] heav;
    logic [16:0] hscale;
    logic [31:0] sdirac;
  } shd_result_t;

  localparam longint unsigned ONE30 = 64'd1073741824;
  localparam longint unsigned HALF30 = 64'd536870912;
  localparam longint unsigned U32MAX = 64'hFFFF_FFFF;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [31:0] in_level_value;
  logic [31:0] out_dirac_value, out_scaled_dirac;
  logic [16:0] out_heaviside_value, out_scaled_heaviside;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  smoothed_heaviside_dirac u_top (.*);

  logic [31:0] pending_levels[$];
  shd_result_t expected_results[$];
  longint unsigned band_mirror, inv_mirror;
  int send_idle_pct, recv_idle_pct;
  int mismatch_count, watchdog;
  bit hold_req, hold_done;
  int hold_cnt;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned quarter_wave_sine(longint unsigned z);
    longint unsigned z2, r;
    z2 = (z * z) >> 30;
    r = shd_pkg::SIN_COEF[6];
    for (int k = 5; k >= 0; k--) r = longint'(shd_pkg::SIN_COEF[k]) - ((r * z2) >> 30);
    r = (r * z) >> 30;
    if (r > ONE30) r = ONE30;
    return r;
  endfunction

  function automatic longint unsigned clamp_q16(longint sum);
    if (sum < 0) sum = 0;
    if (sum > 2 * longint'(ONE30)) sum = 2 * longint'(ONE30);
    return longint'(unsigned'(sum)) >> 15;
  endfunction

  function automatic shd_result_t predict_level_set(logic [31:0] level);
    shd_result_t res;
    longint psi, eps, u, xs, s, c, ts, sum, sqt, stp, x2h;
    longint unsigned mag, m, dirac, heav, hscale, sdirac, sq, st, onepx;
    bit neg;
    psi = longint'(signed'(level));
    eps = longint'(band_mirror);
    neg = psi < 0;
    mag = neg ? -psi : psi;
    if (psi < -eps) begin
      dirac = 0; heav = 0; hscale = 0;
    end else if (psi > eps) begin
      dirac = 0; heav = 65536; hscale = 65536;
    end else begin
      m = mag * inv_mirror;
      if (m >= (64'd1 << 32)) u = ONE30;
      else u = m >> 2;
      xs = neg ? -u : u;
      if (u <= HALF30) begin
        s = quarter_wave_sine(2 * u);
        c = quarter_wave_sine(ONE30 - 2 * u);
      end else begin
        s = quarter_wave_sine(2 * (ONE30 - u));
        c = -longint'(quarter_wave_sine(2 * u - ONE30));
      end
      dirac = (longint'(ONE30) + c) * inv_mirror >> 31;
      if (dirac > U32MAX) dirac = U32MAX;
      ts = (s * longint'(shd_pkg::INV_PI_Q30)) >> 30;
      sum = longint'(ONE30) + xs + (neg ? -ts : ts);
      heav = clamp_q16(sum);
      sq = (s * s) >> 30;
      sqt = (sq * shd_pkg::INV_2PI2_Q30) >> 30;
      onepx = longint'(ONE30) + xs;
      st = (s * onepx) >> 30;
      stp = (st * shd_pkg::INV_PI_Q30) >> 30;
      x2h = (u * u) >> 31;
      sum = longint'(HALF30) + xs + x2h + sqt + (neg ? -stp : stp);
      hscale = clamp_q16(sum);
    end
    sdirac = (heav * dirac) >> 15;
    if (sdirac > U32MAX) sdirac = U32MAX;
    res.dirac = dirac[31:0];
    res.heav = heav[16:0];
    res.hscale = hscale[16:0];
    res.sdirac = sdirac[31:0];
    return res;
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_levels.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_level_value <= pending_levels.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= 80;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(0, 99) < recv_idle_pct;
    end
  end

  // transfer monitor and checker
  always @(posedge clk) begin
    shd_result_t want, got;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        watchdog <= 0;
      end else begin
        watchdog <= watchdog + 1;
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_level_set(in_level_value));
      end
      if (out_valid && !out_stall) begin
        got = '{out_dirac_value, out_heaviside_value, out_scaled_heaviside, out_scaled_dirac};
        if (expected_results.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) $display("unexpected result %h", got);
        end else begin
          want = expected_results.pop_front();
          if (want !== got) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
              $display("mismatch: dirac %h/%h heav %h/%h hscale %h/%h sdirac %h/%h (exp/act)",
                       want.dirac, got.dirac, want.heav, got.heav,
                       want.hscale, got.hscale, want.sdirac, got.sdirac);
          end
        end
      end
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic write_reg(shd_pkg::shd_reg_t idx, logic [30:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(4 * int'(idx)); pwdata <= {1'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == shd_pkg::REG_BAND) band_mirror = value;
    else inv_mirror = value;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_levels.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (25) @(posedge clk);
  endtask

  function automatic logic [31:0] random_level();
    longint unsigned mag;
    if ($urandom_range(0, 99) < 20) return $urandom;
    mag = $urandom_range(0, 31'(band_mirror < 64'h7FFF_FFFF ? band_mirror + 1 : band_mirror));
    return $urandom_range(0, 1) ? 32'(-longint'(mag)) : 32'(mag);
  endfunction

  task automatic run_phase(logic [30:0] eps, logic [30:0] inv, int count);
    write_reg(shd_pkg::REG_BAND, eps);
    write_reg(shd_pkg::REG_INV, inv);
    for (int i = 0; i < count; i++) pending_levels.push_back(random_level());
    drain();
  endtask

  initial begin
    logic [31:0] e;
    rst_n = 0; in_valid = 0; in_level_value = 0; out_stall = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    band_mirror = 65536; inv_mirror = 65536;
    send_idle_pct = 10; recv_idle_pct = 88;
    mismatch_count = 0; watchdog = 0; hold_req = 0; hold_done = 0; hold_cnt = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: reset values, band edges and extremes
    e = band_mirror;
    foreach (e[i]) ;
    pending_levels = '{32'd0, e, -e, e + 1, -e - 1, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'hFFFF_FFFF, 32'd1, e >> 1, -(e >> 1), e >> 2, -(e >> 2),
                       (e >> 1) + 1, 32'h5555_5555, 32'hAAAA_AAAA};
    drain();
    run_phase(31'd65536, 31'd65536, 110);
    // reciprocal too large: coordinate saturates at one
    run_phase(31'd262144, 31'd65536, 110);
    // sender keeps offering while the receiver holds off
    hold_req = 1;
    run_phase(31'd131072, 31'd32768, 110);
    send_idle_pct = 88; recv_idle_pct = 10;
    run_phase(31'h7FFF_FFFF, 31'h7FFF_FFFF, 110);
    run_phase(31'd1, 31'h7FFF_FFFF, 110);
    send_idle_pct = 0; recv_idle_pct = 0;
    run_phase(31'h7FFF_FFFF, 31'd1, 110);
    run_phase(31'd65536, 31'd65536, 80);
    drain();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

>>> smoothed_heaviside_dirac.f
+incdir+sv
sv/shd_pkg.sv
sv/shd_front.sv
sv/shd_qsine.sv
sv/shd_back.sv
sv/smoothed_heaviside_dirac.sv
tb/smoothed_heaviside_dirac_tb.sv
